[hw/rtl/double_ended_queue_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the double-ended queue unit.
// Both macros check a property on the rising clock edge while reset is off.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DQU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dqu_pkg.sv]
// ----------------------------------------------------------------------------
// dqu_pkg
// Types and codes shared by the double-ended queue unit and its submodules.
// ----------------------------------------------------------------------------
`default_nettype none

package dqu_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned ENTRY_W = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4,
        OP_PEEK       = 3'd5
    } dqu_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } dqu_status_t;

    // Opcode travels as raw bits so that the unused codes can be carried.
    typedef struct packed {
        logic [2:0]         opcode;
        logic [VALUE_W-1:0] push_value;
    } dqu_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] front_value;
        logic [VALUE_W-1:0] back_value;
        logic [ENTRY_W-1:0] entry_count;
        logic               is_empty;
        logic [1:0]         status;
    } dqu_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic fetch;
    } dqu_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/dqu_ctrl.sv]
// ----------------------------------------------------------------------------
// dqu_ctrl
// Sequencer of the queue unit: accept, update, read back, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    output logic                 done,
    output dqu_pkg::dqu_cmd_t    cmd
);
    import dqu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_RESP
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        cmd.capture = accept;
        cmd.execute = (state_reg == S_EXEC);
        cmd.fetch   = (state_reg == S_READ);
    end

    assign busy = busy_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    state_reg <= S_RESP;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                S_RESP:
                begin
                    // A new word may be taken while the result is on the port.
                    done_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/dqu_datapath.sv]
// ----------------------------------------------------------------------------
// dqu_datapath
// Ring store, head pointer, count and reversal flag of the queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

module dqu_datapath
#(
    parameter int unsigned DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dqu_pkg::dqu_cmd_t cmd,
    input  wire dqu_pkg::dqu_in_t  item,
    output dqu_pkg::dqu_out_t      result
);
    import dqu_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [2:0]         op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [AW-1:0]      head_reg, head_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               rev_reg, rev_next;
    logic [1:0]         status_reg, status_next;
    logic [VALUE_W-1:0] rd_head_reg, rd_tail_reg;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      head_inc, head_dec;
    logic [AW:0]        end_sum, tail_sum;
    logic [AW-1:0]      end_slot, tail_slot;
    logic               at_head;
    logic [31:0]        count_ext;

    always_comb
    begin
        head_inc = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
        head_dec = (head_reg == '0) ? LAST_SLOT : head_reg - 1'b1;

        // One past the tail; stays below twice the depth.
        end_sum  = {1'b0, head_reg} + (AW + 1)'(count_reg);
        end_slot = (end_sum >= DEPTH_X) ? AW'(end_sum - DEPTH_X) : end_sum[AW-1:0];

        // Tail slot; only meaningful when the queue holds a value.
        tail_sum  = end_sum - 1'b1;
        tail_slot = (tail_sum >= DEPTH_X) ? AW'(tail_sum - DEPTH_X) : tail_sum[AW-1:0];
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        status_next = ST_OK;
        wr_en       = 1'b0;
        wr_addr     = end_slot;
        at_head     = 1'b0;
        case (op_reg)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                at_head = (op_reg == OP_PUSH_FRONT) ^ rev_reg;
                if (count_reg == FULL_CNT)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (at_head)
                    begin
                        head_next = head_dec;
                        wr_addr   = head_dec;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                at_head = (op_reg == OP_POP_FRONT) ^ rev_reg;
                if (count_reg == '0)
                begin
                    status_next = ST_UNDERFLOW;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    if (at_head)
                    begin
                        head_next = head_inc;
                    end
                end
            end
            OP_REVERSE:
            begin
                rev_next = !rev_reg;
            end
            default:
            begin
                // Peek and the unused codes leave the state alone.
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= item.opcode;
            value_reg <= item.push_value;
        end
        if (cmd.execute)
        begin
            status_reg <= status_next;
            if (wr_en)
            begin
                mem[wr_addr] <= value_reg;
            end
        end
        if (cmd.fetch)
        begin
            rd_head_reg <= mem[head_reg];
            rd_tail_reg <= mem[tail_slot];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end
        else if (cmd.execute)
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

    assign count_ext = 32'(count_reg);

    always_comb
    begin
        result.is_empty    = (count_reg == '0);
        result.entry_count = count_ext[ENTRY_W-1:0];
        result.status      = status_reg;
        if (count_reg == '0)
        begin
            result.front_value = '0;
            result.back_value  = '0;
        end
        else
        begin
            result.front_value = rev_reg ? rd_tail_reg : rd_head_reg;
            result.back_value  = rev_reg ? rd_head_reg : rd_tail_reg;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of 64-bit values with push, pop, reverse, peek.
// ----------------------------------------------------------------------------
// The unit takes one command word at a rising edge where start is high and
// busy is low. The word holds an opcode and a value for the push commands.
// After the update the unit reports the front and back values, the number of
// stored values, an empty flag and a status (ok, underflow, overflow).
// The result word is on the result port for exactly one cycle while done is
// high; the receiver cannot hold it off, so it must take it in that cycle.
// After the accepting edge the sequencer first updates the pointers and
// writes the ring store, then reads the head and tail entries through the
// store's two read ports, and then presents the registered result. Busy drops
// in the done cycle, so a new word may be taken while the result is shown;
// until then busy holds new words off, as the store's read-after-write needs.
// Reset clears the head pointer, the count, the reversal flag and the
// sequencer. The ring store needs no clearing, because only written entries
// are ever shown.
// ----------------------------------------------------------------------------
`default_nettype none
`include "double_ended_queue_unit_macros.svh"

module double_ended_queue_unit
#(
    parameter int unsigned DEPTH = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire dqu_pkg::dqu_in_t  item,
    output logic                   done,
    output dqu_pkg::dqu_out_t      result
);
    import dqu_pkg::*;

    // Command bundle from the sequencer to the datapath.
    dqu_cmd_t cmd;

    // The sequencer walks through accept, update, read back and respond.
    dqu_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // The datapath holds the ring store and the queue pointers.
    dqu_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .item   (item),
        .result (result)
    );

    // A result is only produced after a word was in flight.
    `DQU_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, $past(busy), "done without prior work")

    // An accepted word keeps the unit busy in the following cycle.
    `DQU_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !done, "accept not held")

    // The done strobe lasts a single cycle.
    `DQU_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "done held for two cycles")

    // An empty queue reports zero at both ends.
    `DQU_ASSERT_SAME(a_empty_zero, clk, rst_n, done && result.is_empty, (result.front_value == '0) && (result.back_value == '0), "empty queue shows a value")

endmodule

`default_nettype wire
